@@ design/ctw_pkg.sv @@
// ============================================================================
// Text console writer package
// Shared types and constants for the text console writer block.
// ============================================================================
package ctw_pkg;

  localparam int KIND_W      = 2;
  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 7;
  localparam int FORE_W      = 4;
  localparam int BACK_W      = 3;
  localparam int CELL_IDX_W  = 11;
  localparam int COL_OUT_W   = 7;
  localparam int ROW_OUT_W   = 5;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 7'h0F;
  localparam logic [FORE_W-1:0] RESET_FORE = 4'hF;
  localparam logic [BACK_W-1:0] RESET_BACK = 3'h0;

  localparam logic REG_FORE = 1'b0;
  localparam logic REG_BACK = 1'b1;

  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic [CHAR_W-1:0] ch;
  } ctw_cell_t;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [CHAR_W-1:0]     char_code;
    logic [CELL_IDX_W-1:0] cell_index;
  } ctw_cmd_t;

  typedef struct packed {
    logic [ATTR_W-1:0]    read_attr;
    logic [CHAR_W-1:0]    read_char;
    logic                 scrolled;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;
  } ctw_result_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FILL,
    ST_READ,
    ST_RESP
  } ctw_state_t;

endpackage

@@ design/ctw_mem.sv @@
// ============================================================================
// Text console cell store
// Single-port-write, single-port-read memory holding character and attribute.
// ============================================================================
module ctw_mem
  import ctw_pkg::*;
#(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  ctw_cell_t     wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output ctw_cell_t     rdata
);

  ctw_cell_t mem [DEPTH];
  ctw_cell_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/ctw_seq.sv @@
// ============================================================================
// Text console sequencer
// Cursor state, store access control and the walker for whole-store passes.
// ============================================================================
module ctw_seq
  import ctw_pkg::*;
#(
  parameter int COLUMNS        = 80,
  parameter int ROWS_ON_SCREEN = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  ctw_cmd_t          cmd,
  input  logic [ATTR_W-1:0] attr,
  output logic              res_valid,
  input  logic              res_ack,
  output ctw_result_t       res
);

  localparam int CELLS = COLUMNS * ROWS_ON_SCREEN;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS_ON_SCREEN + 1);

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_COPY = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] ROW_SPAN  = AW'(COLUMNS);
  localparam logic [CW:0]   COL_END   = (CW + 1)'(COLUMNS);
  localparam logic [RW-1:0] ROW_END   = RW'(ROWS_ON_SCREEN);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS_ON_SCREEN - 1);

  ctw_state_t        state_r, state_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_addr_r, pend_addr_nxt;
  ctw_cmd_t          cmd_r, cmd_nxt;
  logic              scrolled_r, scrolled_nxt;
  logic [CHAR_W-1:0] rchar_r, rchar_nxt;
  logic [ATTR_W-1:0] rattr_r, rattr_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  ctw_cell_t         mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  ctw_cell_t         mem_rdata;

  logic [AW-1:0]     row_base;
  logic [AW-1:0]     cur_addr;
  logic [CW:0]       col_inc;

  assign row_base = AW'(AW'(row_r) * ROW_SPAN);
  assign cur_addr = row_base + AW'(col_r);
  assign col_inc  = {1'b0, col_r} + (CW + 1)'(1);

  ctw_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      col_r      <= '0;
      row_r      <= '0;
      ptr_r      <= '0;
      pend_r     <= 1'b0;
      scrolled_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      ptr_r      <= ptr_nxt;
      pend_r     <= pend_nxt;
      scrolled_r <= scrolled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    cmd_r       <= cmd_nxt;
    rchar_r     <= rchar_nxt;
    rattr_r     <= rattr_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    cmd_nxt       = cmd_r;
    scrolled_nxt  = scrolled_r;
    rchar_nxt     = rchar_r;
    rattr_nxt     = rattr_r;
    mem_we        = 1'b0;
    mem_waddr     = ptr_r;
    mem_wdata     = '{attr: attr, ch: CH_BLANK};
    mem_re        = 1'b0;
    mem_raddr     = ptr_r;
    cmd_ready     = 1'b0;
    res_valid     = 1'b0;

    case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '{attr: RESET_ATTR, ch: CH_BLANK};
        if (ptr_r == LAST_CELL) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_nxt      = cmd;
          scrolled_nxt = 1'b0;
          rchar_nxt    = '0;
          rattr_nxt    = '0;
          state_nxt    = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (cmd_r.kind)
          KIND_PUT: begin
            if (cmd_r.char_code == CH_NEWLINE) begin
              col_nxt = '0;
              row_nxt = row_r + RW'(1);
            end else if (cmd_r.char_code == CH_RETURN) begin
              col_nxt = '0;
            end else if (cmd_r.char_code == CH_BACKSPACE) begin
              if (col_r != '0) begin
                col_nxt   = col_r - CW'(1);
                mem_we    = 1'b1;
                mem_waddr = cur_addr - AW'(1);
              end
            end else begin
              mem_we    = 1'b1;
              mem_waddr = cur_addr;
              mem_wdata = '{attr: attr, ch: cmd_r.char_code};
              if (col_inc >= COL_END) begin
                col_nxt = '0;
                row_nxt = row_r + RW'(1);
              end else begin
                col_nxt = col_inc[CW-1:0];
              end
            end
            // The row only ever grows by one, so reaching the row count
            // means one step past the bottom line.
            if (row_nxt == ROW_END) begin
              row_nxt      = ROW_LAST;
              scrolled_nxt = 1'b1;
              ptr_nxt      = '0;
              pend_nxt     = 1'b0;
              state_nxt    = ST_SCROLL;
            end else begin
              state_nxt = ST_RESP;
            end
          end
          KIND_CLEAR: begin
            col_nxt   = '0;
            row_nxt   = '0;
            ptr_nxt   = '0;
            state_nxt = ST_FILL;
          end
          KIND_READ: begin
            if (32'(cmd_r.cell_index) < 32'(CELLS)) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(cmd_r.cell_index);
              state_nxt = ST_READ;
            end else begin
              state_nxt = ST_RESP;
            end
          end
          default: begin
            state_nxt = ST_RESP;
          end
        endcase
      end

      ST_SCROLL: begin
        // Read one row ahead and write the word fetched in the last cycle.
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r;
          mem_wdata = mem_rdata;
        end
        if (ptr_r == LAST_COPY) begin
          pend_nxt  = 1'b0;
          state_nxt = ST_FILL;
        end else begin
          mem_re        = 1'b1;
          mem_raddr     = ptr_r + ROW_SPAN;
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r;
          ptr_nxt       = ptr_r + AW'(1);
        end
      end

      ST_FILL: begin
        mem_we = 1'b1;
        if (ptr_r == LAST_CELL) begin
          ptr_nxt   = '0;
          state_nxt = ST_RESP;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      ST_READ: begin
        rchar_nxt = mem_rdata.ch;
        rattr_nxt = mem_rdata.attr;
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        res_valid = 1'b1;
        if (res_ack) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res.cursor_col = COL_OUT_W'(col_r);
  assign res.cursor_row = ROW_OUT_W'(row_r);
  assign res.scrolled   = scrolled_r;
  assign res.read_char  = rchar_r;
  assign res.read_attr  = rattr_r;

endmodule

@@ design/text_console_writer.sv @@
// ============================================================================
// Text console writer
// Text-mode console engine with cursor, colour registers and scrolling.
// ============================================================================
// The console keeps a COLUMNS x ROWS_ON_SCREEN screen of characters and
// attributes in one memory, plus a cursor, and returns exactly one result item
// for every input item. After reset a clearing pass writes every cell with a
// space and attribute 0x0F, during which in_tready stays low while
// configuration writes are still taken. Items are handled one at a time by a
// small sequencer that walks a single address counter over the store. A put
// item that does not scroll passes from the execute state to the response
// state; a read item also passes through a read state, since the memory read
// is registered. A clear item walks the whole store, and a put that runs off
// the bottom row copies every row up one through the single read and write
// port and then blanks the bottom row. Blanked cells take the current
// attribute, (back_color << 4) | fore_color. The result waits in an output
// register, so the block can accept the next item while the previous result
// has not been taken yet.
module text_console_writer
  import ctw_pkg::*;
#(
  parameter int COLUMNS        = 80,
  parameter int ROWS_ON_SCREEN = 25
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input items.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // char_code[7:0], cell_index[18:8]
  input  logic [KIND_W-1:0]      in_tuser,   // kind[1:0]
  // Result items.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // cursor_col[6:0], cursor_row[11:7],
                                             // scrolled[12], read_char[20:13],
                                             // read_attr[27:21]
  // Register writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [FORE_W-1:0]      cfg_data
);

  logic [FORE_W-1:0] fore_r;
  logic [BACK_W-1:0] back_r;
  logic              out_valid_r;
  ctw_result_t       out_data_r;

  ctw_cmd_t          cmd;
  logic              res_valid;
  logic              res_ack;
  ctw_result_t       res;
  logic [ATTR_W-1:0] attr;

  // Registers are always writable; the block is to be written only while idle, a rule the block does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fore_r <= RESET_FORE;
      back_r <= RESET_BACK;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FORE: fore_r <= cfg_data;
        REG_BACK: back_r <= cfg_data[BACK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign attr = {back_r, fore_r};

  assign cmd.kind       = in_tuser;
  assign cmd.char_code  = in_tdata[CHAR_W-1:0];
  assign cmd.cell_index = in_tdata[CHAR_W +: CELL_IDX_W];

  ctw_seq #(
    .COLUMNS        (COLUMNS),
    .ROWS_ON_SCREEN (ROWS_ON_SCREEN)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd_ready (in_tready),
    .cmd       (cmd),
    .attr      (attr),
    .res_valid (res_valid),
    .res_ack   (res_ack),
    .res       (res)
  );

  // The sequencer hands its result over once the output register is empty or its result is being taken.
  assign res_ack = res_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ack) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - $bits(ctw_result_t))'(0), out_data_r};

endmodule

@@ tb/console_checker.sv @@
// ============================================================================
// Console result checker
// Watches the item, result and register channels of the text console writer,
// keeps its own copy of the screen, cursor and colours, and compares every
// result item field by field with the oldest predicted one.
// ============================================================================
module console_checker
  import ctw_pkg::*;
#(
  parameter int COLUMNS        = 80,
  parameter int ROWS_ON_SCREEN = 25
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [KIND_W-1:0]      in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [FORE_W-1:0]      cfg_data,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS     = COLUMNS * ROWS_ON_SCREEN;
  localparam int RES_W     = $bits(ctw_result_t);
  localparam int PRINT_CAP = 60;

  logic [CHAR_W-1:0] screen_char [CELLS];
  logic [ATTR_W-1:0] screen_attr [CELLS];
  int                cur_col;
  int                cur_row;
  logic [FORE_W-1:0] fore;
  logic [BACK_W-1:0] back;

  ctw_result_t awaited_results [$];
  ctw_result_t got;
  ctw_result_t want;
  int          result_no;

  function automatic logic [ATTR_W-1:0] pen_attr();
    return {back, fore};
  endfunction

  function automatic void blank_cells(int lo, int hi);
    for (int i = lo; i < hi && i < CELLS; i++) begin
      screen_char[i] = CH_BLANK;
      screen_attr[i] = pen_attr();
    end
  endfunction

  // Moves every row up one and blanks the bottom row.
  function automatic void scroll_screen();
    for (int i = 0; i + COLUMNS < CELLS; i++) begin
      screen_char[i] = screen_char[i + COLUMNS];
      screen_attr[i] = screen_attr[i + COLUMNS];
    end
    blank_cells(CELLS - COLUMNS, CELLS);
    cur_row = ROWS_ON_SCREEN - 1;
  endfunction

  function automatic ctw_result_t console_update(input logic [KIND_W-1:0] kind,
                                                 input logic [CHAR_W-1:0] ch,
                                                 input logic [CELL_IDX_W-1:0] idx);
    ctw_result_t r;
    int          pos;
    r = '0;
    case (kind)
      KIND_PUT: begin
        if (ch == CH_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else if (ch == CH_RETURN) begin
          cur_col = 0;
        end else if (ch == CH_BACKSPACE) begin
          if (cur_col > 0) begin
            cur_col--;
            pos = cur_row * COLUMNS + cur_col;
            blank_cells(pos, pos + 1);
          end
        end else begin
          pos = cur_row * COLUMNS + cur_col;
          if (pos < CELLS) begin
            screen_char[pos] = ch;
            screen_attr[pos] = pen_attr();
          end
          cur_col++;
          if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        if (cur_row >= ROWS_ON_SCREEN) begin
          scroll_screen();
          r.scrolled = 1'b1;
        end
      end
      KIND_CLEAR: begin
        blank_cells(0, CELLS);
        cur_col = 0;
        cur_row = 0;
      end
      KIND_READ: begin
        if (int'(idx) < CELLS) begin
          r.read_char = screen_char[idx];
          r.read_attr = screen_attr[idx];
        end
      end
      default: ;
    endcase
    r.cursor_col = cur_col[COL_OUT_W-1:0];
    r.cursor_row = cur_row[ROW_OUT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_CAP)
      $display("[%0t] result %0d: %s", $realtime, result_no, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fore      = RESET_FORE;
      back      = RESET_BACK;
      cur_col   = 0;
      cur_row   = 0;
      result_no = 0;
      fail_count = 0;
      awaited_results.delete();
      blank_cells(0, CELLS);
      pending <= 0;
    end else begin
      // A result accepted at the same edge as an item always belongs to an
      // earlier item, so it is compared first.
      if (out_tvalid && out_tready) begin
        result_no++;
        if (awaited_results.size() == 0) begin
          report_mismatch("result item arrived with no item awaiting it");
        end else begin
          want = awaited_results.pop_front();
          got  = out_tdata[RES_W-1:0];
          if (got.cursor_col !== want.cursor_col)
            report_mismatch($sformatf("cursor_col %0d, expected %0d",
                                      got.cursor_col, want.cursor_col));
          if (got.cursor_row !== want.cursor_row)
            report_mismatch($sformatf("cursor_row %0d, expected %0d",
                                      got.cursor_row, want.cursor_row));
          if (got.scrolled !== want.scrolled)
            report_mismatch($sformatf("scrolled %0b, expected %0b",
                                      got.scrolled, want.scrolled));
          if (got.read_char !== want.read_char)
            report_mismatch($sformatf("read_char %0h, expected %0h",
                                      got.read_char, want.read_char));
          if (got.read_attr !== want.read_attr)
            report_mismatch($sformatf("read_attr %0h, expected %0h",
                                      got.read_attr, want.read_attr));
          if (out_tdata[OUT_TDATA_W-1:RES_W] !== '0)
            report_mismatch($sformatf("padding bits %0h, expected 0",
                                      out_tdata[OUT_TDATA_W-1:RES_W]));
        end
      end
      if (in_tvalid && in_tready)
        awaited_results.push_back(console_update(in_tuser, in_tdata[CHAR_W-1:0],
                                                 in_tdata[CHAR_W +: CELL_IDX_W]));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FORE: fore = cfg_data;
          REG_BACK: back = cfg_data[BACK_W-1:0];
          default: ;
        endcase
      end
      pending <= awaited_results.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// ============================================================================
// Text console writer testbench
// Drives put, clear, read and spare items into the console in random bursts
// while the result side stalls on its own pattern, changes the colour
// registers between phases, and leaves all checking to the console checker.
// ============================================================================
module tb;
  import ctw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS         = 80;
  localparam int ROWS_ON_SCREEN  = 25;
  localparam int CELLS           = COLUMNS * ROWS_ON_SCREEN;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 108;
  // A clear or a scroll keeps both channels quiet while it walks the whole store,
  // and so does the clearing pass after reset; the limit is well beyond that.
  localparam int STALL_LIMIT     = 10000;
  // Long enough for a scroll or clear still under way to finish.
  localparam int SETTLE_CYCLES   = 2100;

  // The kind code that the block does not use.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [KIND_W-1:0]      in_tuser   = KIND_PUT;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index  = REG_FORE;
  logic [FORE_W-1:0]      cfg_data   = '0;

  int fail_count;
  int pending;

  text_console_writer #(
    .COLUMNS        (COLUMNS),
    .ROWS_ON_SCREEN (ROWS_ON_SCREEN)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  console_checker #(
    .COLUMNS        (COLUMNS),
    .ROWS_ON_SCREEN (ROWS_ON_SCREEN)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // The result side cycles through four moods, set by pace_cnt[10:9]: always
  // ready, ready at random half the time, ready when pace_cnt[2:0] is zero, and
  // ready most of the time with the odd stall.
  logic [10:0] pace_cnt = '0;

  always @(posedge clk) begin
    pace_cnt <= pace_cnt + 11'd1;
    case (pace_cnt[10:9])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 1) == 0);
      2'd2: out_tready <= (pace_cnt[2:0] == 3'd0);
      default: out_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // The watchdog ends the run when nothing at all is accepted for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sender pacing: items go out in bursts of random length, with a random gap
  // in front of each burst unless the phase runs the sender without gaps.
  int burst_left = 0;
  bit steady     = 1'b0;

  // Every task below is entered just after a rising edge and returns just
  // after the edge that completed its handshake, so each drive is one
  // nonblocking assignment per signal per time step.
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                           input logic [CELL_IDX_W-1:0] idx);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(IN_TDATA_W - CHAR_W - CELL_IDX_W){1'b0}}, idx, ch};
    do @(posedge clk); while (!in_tready);
  endtask

  // Waits until every item sent so far has had its result taken. The first
  // edge lets the checker log an item accepted at the edge just gone.
  task automatic wait_for_results();
    do @(posedge clk); while (pending != 0);
  endtask

  // Both colour registers, foreground first. The background value is four bits
  // wide on the port, so its top bit checks that the block drops it.
  task automatic write_colours(input logic [FORE_W-1:0] fore_val,
                               input logic [FORE_W-1:0] back_val);
    cfg_valid <= 1'b1;
    cfg_index <= REG_FORE;
    cfg_data  <= fore_val;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_BACK;
    cfg_data  <= back_val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  int                    phase;
  int                    n;
  int                    pick;
  int                    nl_weight;
  logic [KIND_W-1:0]     kind;
  logic [CHAR_W-1:0]     ch;
  logic [CELL_IDX_W-1:0] idx;

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items, all under the reset colours. The first few read the
    // screen as the clearing pass left it, at both ends and beyond the end.
    send_item(KIND_READ, 8'h00, 11'd0);
    send_item(KIND_READ, 8'hFF, 11'(CELLS - 1));
    send_item(KIND_READ, 8'h00, 11'(CELLS));
    send_item(KIND_READ, 8'h55, 11'h7FF);
    // The spare kind must leave everything alone.
    send_item(KIND_SPARE, 8'hFF, 11'h7FF);
    // Extreme bytes are stored like any other character.
    send_item(KIND_PUT, 8'h00, 11'h000);
    send_item(KIND_PUT, 8'hFF, 11'h7FF);
    send_item(KIND_PUT, 8'h41, 11'h2AA);
    // Backspace blanks the cell it steps onto.
    send_item(KIND_PUT, CH_BACKSPACE, 11'h555);
    send_item(KIND_READ, 8'h00, 11'd2);
    send_item(KIND_READ, 8'h00, 11'd1);
    // Return, then a backspace at column zero that must change nothing.
    send_item(KIND_PUT, CH_RETURN, 11'd0);
    send_item(KIND_PUT, CH_BACKSPACE, 11'd0);
    send_item(KIND_READ, 8'h00, 11'd0);
    send_item(KIND_PUT, CH_NEWLINE, 11'd0);
    send_item(KIND_PUT, 8'h7E, 11'd0);
    send_item(KIND_READ, 8'h00, 11'(COLUMNS));
    // Clear homes the cursor and never reports a scroll.
    send_item(KIND_CLEAR, 8'hAA, 11'h3FF);
    send_item(KIND_READ, 8'h00, 11'd0);
    send_item(KIND_READ, 8'h00, 11'(COLUMNS));
    send_item(KIND_PUT, CH_NEWLINE, 11'd0);
    send_item(KIND_READ, 8'h00, 11'(CELLS - 1));

    // Random phases. Most items are lines of printable text broken by
    // newlines, so the cursor soon reaches the bottom row and the screen
    // scrolls; reads sample the top rows, the bottom rows or anywhere at all,
    // and the rest is backspaces, returns, raw bytes, clears and spare kinds.
    for (phase = 0; phase < PHASES; phase++) begin
      in_tvalid <= 1'b0;
      wait_for_results();
      case (phase)
        0: write_colours(4'h0, 4'hF);
        1: write_colours(4'hF, 4'h0);
        default: write_colours(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      endcase
      // One phase has no newlines so that lines wrap at the last column, and
      // another runs the sender without gaps.
      nl_weight = (phase == 2) ? 0 : 70;
      steady    = (phase == 4);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 999);
        kind = KIND_PUT;
        ch   = 8'(8'h20 + $urandom_range(0, 94));
        idx  = 11'($urandom_range(0, 2047));
        if (pick < 30) begin
          ch = CH_RETURN;
        end else if (pick < 80) begin
          ch = CH_BACKSPACE;
        end else if (pick < 140) begin
          ch = 8'($urandom_range(0, 255));
        end else if (pick < 240) begin
          kind = KIND_READ;
          ch   = 8'($urandom_range(0, 255));
          case ($urandom_range(0, 2))
            0: idx = 11'($urandom_range(0, 4 * COLUMNS - 1));
            1: idx = 11'($urandom_range(CELLS - 3 * COLUMNS, CELLS - 1));
            default: ;
          endcase
        end else if (pick < 248) begin
          kind = KIND_SPARE;
          ch   = 8'($urandom_range(0, 255));
        end else if (pick < 253) begin
          kind = KIND_CLEAR;
          ch   = 8'($urandom_range(0, 255));
        end else if (pick < 253 + nl_weight) begin
          ch = CH_NEWLINE;
        end
        send_item(kind, ch, idx);
      end
    end

    in_tvalid <= 1'b0;
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
